/* src/ipv6_multicast_text_checker_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the IPv6 multicast text checker.
// The checks compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef IPV6_MULTICAST_TEXT_CHECKER_TOP_ASSERT_SVH
`define IPV6_MULTICAST_TEXT_CHECKER_TOP_ASSERT_SVH
`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define IMC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The expression must never be true outside reset.
`define IMC_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define IMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define IMC_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* src/ipv6mc_pkg.sv */
// ----------------------------------------------------------------------------
// ipv6mc_pkg
// Character codes, limits and the scan state type of the multicast checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv6mc_pkg;

	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam logic [2:0] LEN_MIN   = 3'd7;
	localparam logic [2:0] POS_MAX   = 3'd7;
	localparam logic [2:0] GROUP_MAX = 3'd4;
	localparam logic [2:0] SEG_MAX   = 3'd5;
	localparam logic [2:0] SEG_MIN   = 3'd2;

	// Scan state carried from one character to the next.
	typedef struct packed {
		logic [2:0] position_count;
		logic [2:0] digit_run;
		logic [2:0] segment_count;
		logic       double_seen;
		logic       prev_single_colon;
		logic       failed;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		position_count:    3'd0,
		digit_run:         GROUP_MAX,
		segment_count:     3'd1,
		double_seen:       1'b0,
		prev_single_colon: 1'b0,
		failed:            1'b0
	};

	// True for a lower-case hex digit.
	function automatic logic is_hex_lower(input logic [7:0] c);
		return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_A) && (c <= CH_F));
	endfunction

endpackage

`default_nettype wire

/* src/ipv6_multicast_text_checker_top.sv */
// ----------------------------------------------------------------------------
// ipv6_multicast_text_checker_top
// Checks a textual IPv6 multicast address streamed one character per beat.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one character per beat in s_axis_tdata, with
// s_axis_tlast high on the final character of an address string. Beats
// without tlast produce no output. The beat with tlast produces one master
// beat whose tdata bit 0 is 1 when the whole string is an accepted address.
// A character is registered on acceptance and checked against the scan
// state; the verdict is registered in the result register before the
// master side sees it. One character is taken every cycle, but for the
// stall below; the rate is set by the single scan-state register.
// When the master side stalls with a verdict pending, the input register
// may still take one beat; ordinary characters keep flowing, and only a
// second final character waits until the pending verdict is taken.
// After every final character the scan state returns to its reset value,
// so the next beat starts a new string. Reset clears both valid flags and
// the scan state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ipv6_multicast_text_checker_top_assert.svh"

module ipv6_multicast_text_checker_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] char_code
	input  wire logic       s_axis_tlast,   // last_char
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata    // [0] address_valid, [7:1] zero
);
	import ipv6mc_pkg::*;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;
	logic        advance;
	logic        verdict_load;
	scan_state_t state_q;
	scan_state_t state_next;
	logic        verdict;
	logic        out_valid_q;
	logic        out_bit_q;

	// The registered character moves on when it needs no output slot or one is free.
	assign advance = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign verdict_load = advance && last_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Character check and scan-state update.
	always_comb begin
		state_next = state_q;
		verdict    = 1'b0;
		if (state_q.position_count < 3'd2) begin
			if (char_s1 != CH_F) state_next.failed = 1'b1;
		end else if (state_q.position_count == 3'd2) begin
			if ((char_s1 != CH_0) && (char_s1 != CH_1)) state_next.failed = 1'b1;
		end else if (state_q.position_count == 3'd3) begin
			if (char_s1 == CH_F) state_next.failed = 1'b1;
		end else if (char_s1 == CH_COLON) begin
			if (state_q.prev_single_colon) begin
				// Second colon of a double colon; only one is allowed.
				if (state_q.double_seen) state_next.failed = 1'b1;
				state_next.double_seen       = 1'b1;
				state_next.prev_single_colon = 1'b0;
			end else begin
				if (state_q.digit_run == 3'd0) state_next.failed = 1'b1;
				if (state_q.segment_count <= SEG_MAX) begin
					state_next.segment_count = state_q.segment_count + 3'd1;
				end
				if (state_next.segment_count > SEG_MAX) state_next.failed = 1'b1;
				state_next.digit_run         = 3'd0;
				state_next.prev_single_colon = 1'b1;
			end
		end else if (is_hex_lower(char_s1)) begin
			state_next.prev_single_colon = 1'b0;
			if (state_q.digit_run <= GROUP_MAX) begin
				state_next.digit_run = state_q.digit_run + 3'd1;
			end
			if (state_next.digit_run > GROUP_MAX) state_next.failed = 1'b1;
		end else begin
			state_next.prev_single_colon = 1'b0;
			state_next.failed            = 1'b1;
		end

		if (state_q.position_count < POS_MAX) begin
			state_next.position_count = state_q.position_count + 3'd1;
		end

		// The final character yields the verdict and restarts the scan.
		if (last_s1) begin
			verdict = !state_next.failed
				&& (state_q.position_count >= (LEN_MIN - 3'd1))
				&& (char_s1 != CH_COLON)
				&& (state_next.segment_count >= SEG_MIN);
			state_next = SCAN_RESET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SCAN_RESET;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (verdict_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (verdict_load) begin
			out_bit_q <= verdict;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_bit_q};

	`IMC_NEVER(a_seg_bound, clk, arst_n, state_q.segment_count > (SEG_MAX + 3'd1), "seg overrun")
	`IMC_NEVER(a_run_bound, clk, arst_n, state_q.digit_run > (GROUP_MAX + 3'd1), "run overrun")
	`IMC_ASSERT(a_restart, clk, arst_n, verdict_load |=> (state_q == SCAN_RESET), "no restart")
	`IMC_ASSERT(a_out_src, clk, arst_n, $rose(out_valid_q) |-> $past(verdict_load), "stray verdict")

endmodule

`default_nettype wire
